### rtl/rsp_pkg.sv
// Shared types and constants for the reference-counted slot pool.
// Used by rsp_ctrl, rsp_datapath and refcounted_slot_pool; depends on nothing.
package rsp_pkg;

  localparam int OPCODE_W  = 3;
  localparam int SLOT_W    = 4;
  localparam int ID_W      = 32;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 5;
  localparam int REF_W     = 8;
  localparam int MAX_SLOTS = 16;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 48;

  localparam logic [OPCODE_W-1:0] OP_LOAD    = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_GET     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_FIND    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_HOLD    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNUSED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SATURATED = 3'd5;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WRITE_ID,
    ACT_INC,
    ACT_DEC,
    ACT_CLAIM
  } rsp_act_e;

  typedef enum logic [1:0] {
    RID_ZERO,
    RID_REQ,
    RID_STORED
  } rsp_rid_e;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic commit;
    logic cfg_wr;
    logic sweep_step;
  } rsp_cmd_t;

  typedef struct packed {
    logic out_full;
    logic sweep_last;
  } rsp_stat_t;

endpackage

### rtl/rsp_ctrl.sv
// Sequencing state machine of the slot pool: request decode, commit and recount.
// Depends on rsp_pkg; drives the command struct of rsp_datapath.
module rsp_ctrl
  import rsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  output logic      s_ready_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  rsp_stat_t stat_i,
  output rsp_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_SWEEP  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    s_ready_o   = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        cfg_ready_o = 1'b1;
        s_ready_o   = !cfg_valid_i;
        if (cfg_valid_i) begin
          cmd_o.cfg_wr = 1'b1;
          state_d      = S_SWEEP;
        end else if (s_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_COMMIT;
      end
      S_COMMIT: begin
        if (!stat_i.out_full) begin
          cmd_o.commit = 1'b1;
          s_ready_o    = 1'b1;
          if (s_valid_i) begin
            cmd_o.load_req = 1'b1;
            state_d        = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/rsp_datapath.sv
// Datapath of the slot pool: identifier and count storage, slot search,
// free counter, recount sweep and result register. Depends on rsp_pkg.
module rsp_datapath
  import rsp_pkg::*;
#(
  parameter int HW_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsp_cmd_t            cmd_i,
  output rsp_stat_t           stat_o,
  input  logic [IN_W-1:0]     in_word_i,
  input  logic [COUNT_W-1:0]  cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUT_W-1:0]    out_word_o
);

  localparam int IDX_W = (HW_SLOTS > 1) ? $clog2(HW_SLOTS) : 1;
  localparam logic [COUNT_W-1:0] HW_CNT = COUNT_W'(HW_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HW_SLOTS - 1);

  logic [COUNT_W-1:0]  num_q;
  logic [COUNT_W-1:0]  eff;
  logic [OPCODE_W-1:0] op_q;
  logic [SLOT_W-1:0]   idx_q;
  logic [ID_W-1:0]     sid_q;
  logic [ID_W-1:0]     ids_q [HW_SLOTS];
  logic [REF_W-1:0]    cnt_q [HW_SLOTS];
  logic [COUNT_W-1:0]  free_q, free_d;
  logic [SLOT_W-1:0]   sw_q;
  logic [MAX_SLOTS-1:0] zero_v, sat_v, live_v, match_v;

  logic                in_range;
  logic                free_hit, match_hit;
  logic [SLOT_W-1:0]   free_idx, match_idx;
  logic [STATUS_W-1:0] st_d;
  logic [SLOT_W-1:0]   rslot_d;
  rsp_act_e            act_d;
  rsp_rid_e            rid_d;

  logic [STATUS_W-1:0] st_q;
  logic [SLOT_W-1:0]   tgt_q;
  rsp_act_e            act_q;
  rsp_rid_e            rid_q;

  logic [IDX_W-1:0]    tgt_a;
  logic [ID_W-1:0]     rd_id;
  logic [REF_W-1:0]    rd_cnt;
  logic [ID_W-1:0]     res_id;

  logic                out_valid_q;
  logic [OUT_W-1:0]    out_word_q;

  always_comb begin
    eff = num_q;
    if (eff > HW_CNT) begin
      eff = HW_CNT;
    end
    if (eff == '0) begin
      eff = COUNT_W'(1);
    end
  end

  always_comb begin
    zero_v  = '0;
    sat_v   = '0;
    live_v  = '0;
    match_v = '0;
    for (int i = 0; i < HW_SLOTS; i++) begin
      zero_v[i]  = (cnt_q[i] == '0);
      sat_v[i]   = (cnt_q[i] == '1);
      live_v[i]  = (COUNT_W'(i) < eff);
      match_v[i] = (ids_q[i] == sid_q);
    end
  end

  always_comb begin
    free_hit  = 1'b0;
    match_hit = 1'b0;
    free_idx  = '0;
    match_idx = '0;
    for (int i = HW_SLOTS - 1; i >= 0; i--) begin
      if (live_v[i] && zero_v[i]) begin
        free_hit = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (live_v[i] && !zero_v[i] && match_v[i]) begin
        match_hit = 1'b1;
        match_idx = SLOT_W'(i);
      end
    end
  end

  assign in_range = ({1'b0, idx_q} < eff);

  always_comb begin
    st_d    = ST_OK;
    rslot_d = '0;
    act_d   = ACT_NONE;
    rid_d   = RID_ZERO;
    unique case (op_q)
      OP_LOAD: begin
        rslot_d = idx_q;
        if (!in_range) begin
          st_d = ST_RANGE;
        end else begin
          act_d = ACT_WRITE_ID;
          rid_d = RID_REQ;
        end
      end
      OP_HOLD, OP_RELEASE: begin
        rslot_d = idx_q;
        if (!in_range) begin
          st_d = ST_RANGE;
        end else begin
          rid_d = RID_STORED;
          priority if (zero_v[idx_q]) begin
            st_d = ST_UNUSED;
          end else if (op_q == OP_RELEASE) begin
            act_d = ACT_DEC;
          end else if (sat_v[idx_q]) begin
            st_d = ST_SATURATED;
          end else begin
            act_d = ACT_INC;
          end
        end
      end
      OP_GET: begin
        if (free_hit) begin
          rslot_d = free_idx;
          act_d   = ACT_CLAIM;
          rid_d   = RID_STORED;
        end else begin
          st_d = ST_NO_FREE;
        end
      end
      OP_FIND: begin
        if (match_hit) begin
          rslot_d = match_idx;
          rid_d   = RID_REQ;
        end else begin
          st_d = ST_NOT_FOUND;
        end
      end
      default: st_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q  <= in_word_i[OPCODE_W-1:0];
      idx_q <= in_word_i[OPCODE_W+SLOT_W-1:OPCODE_W];
      sid_q <= in_word_i[OPCODE_W+SLOT_W+ID_W-1:OPCODE_W+SLOT_W];
    end
    if (cmd_i.exec) begin
      st_q  <= st_d;
      tgt_q <= rslot_d;
      act_q <= act_d;
      rid_q <= rid_d;
    end
  end

  assign tgt_a  = tgt_q[IDX_W-1:0];
  assign rd_id  = ids_q[tgt_a];
  assign rd_cnt = cnt_q[tgt_a];

  always_comb begin
    unique case (rid_q)
      RID_REQ:    res_id = sid_q;
      RID_STORED: res_id = rd_id;
      default:    res_id = '0;
    endcase
  end

  always_comb begin
    free_d = free_q;
    if (act_q == ACT_CLAIM && free_q != '0) begin
      free_d = free_q - COUNT_W'(1);
    end
    if (act_q == ACT_DEC && rd_cnt == REF_W'(1)) begin
      free_d = free_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && act_q == ACT_WRITE_ID) begin
      ids_q[tgt_a] <= sid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HW_SLOTS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      unique case (act_q)
        ACT_INC:   cnt_q[tgt_a] <= rd_cnt + REF_W'(1);
        ACT_DEC:   cnt_q[tgt_a] <= rd_cnt - REF_W'(1);
        ACT_CLAIM: cnt_q[tgt_a] <= REF_W'(1);
        default:   cnt_q[tgt_a] <= rd_cnt;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= COUNT_W'(MAX_SLOTS);
      free_q <= HW_CNT;
      sw_q   <= '0;
    end else if (cmd_i.cfg_wr) begin
      num_q  <= cfg_data_i;
      free_q <= '0;
      sw_q   <= '0;
    end else if (cmd_i.sweep_step) begin
      if (live_v[sw_q] && zero_v[sw_q]) begin
        free_q <= free_q + COUNT_W'(1);
      end
      sw_q <= sw_q + SLOT_W'(1);
    end else if (cmd_i.commit) begin
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_word_q <= {4'b0, free_d, res_id, tgt_q, st_q};
    end
  end

  assign stat_o.out_full   = out_valid_q && !out_ready_i;
  assign stat_o.sweep_last = (sw_q == LAST_SLOT);
  assign out_valid_o       = out_valid_q;
  assign out_word_o        = out_word_q;

endmodule

### rtl/refcounted_slot_pool.sv
// Top level of the reference-counted slot pool: stream ports, config port,
// controller and datapath. Depends on rsp_pkg, rsp_ctrl and rsp_datapath.
//
// Each request word is decoded and the slots searched in the execute state
// (lowest free slot, lowest matching in-use slot); the commit state updates
// the chosen slot's count or identifier and loads the result register. A new
// request word is accepted in the commit state of the one before, as long as
// the result register is drained; a result that is not taken holds the commit
// step. A write of num_slots starts a recount of the free slots that visits
// one slot per cycle over min(POOL_SLOTS, 16) slots, accepting no requests.
module refcounted_slot_pool
  import rsp_pkg::*;
#(
  parameter int POOL_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0: opcode[2:0], slot_index[6:3], surface_id[38:7].
  input  logic [IN_W-1:0]     s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0: status[2:0], result_slot[6:3], result_id[38:7],
  // free_count[43:39].
  output logic [OUT_W-1:0]    m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [COUNT_W-1:0]  cfg_data_i
);

  localparam int HW_SLOTS = (POOL_SLOTS < MAX_SLOTS) ? POOL_SLOTS : MAX_SLOTS;

  rsp_cmd_t  cmd;
  rsp_stat_t stat;

  rsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rsp_datapath #(
    .HW_SLOTS (HW_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (s_axis_tdata),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (m_axis_tdata)
  );

endmodule
